/* design/ppd_pkg.sv */
// Shared types and codes for the PPM stream decoder.
// Used by ppd_front, ppd_queue, ppd_back and ppm_stream_decoder; no dependencies.
`default_nettype none
package ppd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_SIZE   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_FORMAT = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE   = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
   localparam logic [2:0] ST_SHORT      = 3'd4;
   localparam logic [2:0] ST_UNEXPECTED = 3'd5;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] CHAN_FULL    = 8'd255;

   // Work for one input byte: an optional channel, size and status, in that order
   typedef struct packed {
      logic        chan_v;
      logic [31:0] chan_u;
      logic [31:0] chan_max;
      logic [1:0]  chan_idx;
      logic        size_v;
      logic [14:0] size_w;
      logic [14:0] size_h;
      logic        stat_v;
      logic [2:0]  stat;
   } ppd_entry_type;

   // Queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } ppd_qstat_type;

endpackage
`default_nettype wire

/* design/ppd_front.sv */
// Front end: header parser and tokenizer, one file byte per transfer.
// Depends on ppd_pkg; pushes one ppd_entry_type per byte that has work.
`default_nettype none
module ppd_front #(
   parameter int MAX_DIM    = 16384,
   parameter int MAX_PIXELS = 16777216
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [7:0]        data_byte,
   input  wire logic              first_byte,
   input  wire logic              final_byte,
   output ppd_pkg::ppd_entry_type entry,
   output logic                   push
);
   import ppd_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int PIX_W  = $clog2(MAX_PIXELS + 1);
   localparam int PROD_W = 2 * DIM_W;

   typedef enum logic [8:0] {
      PH_MAGIC_P   = 9'b000000001,
      PH_MAGIC_NUM = 9'b000000010,
      PH_MAGIC_SP  = 9'b000000100,
      PH_WIDTH     = 9'b000001000,
      PH_HEIGHT    = 9'b000010000,
      PH_MAXV      = 9'b000100000,
      PH_BIN_SEP   = 9'b001000000,
      PH_BIN_LF    = 9'b010000000,
      PH_DATA      = 9'b100000000
   } phase_type;

   typedef struct packed {
      phase_type        ph;
      logic             ascii;
      logic             cmt;
      logic             num;
      logic             done;
      logic [31:0]      acc;
      logic [DIM_W-1:0] wid;
      logic [31:0]      maxv;
      logic [1:0]       cidx;
      logic [PIX_W-1:0] left;
   } fs_type;

   typedef struct packed {
      fs_type        s;
      ppd_entry_type e;
   } fx_type;

   fs_type state_ff, state_in;
   fx_type work;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_dig(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // Parser state at reset and at the start of a file
   function automatic fs_type idle_state();
      fs_type s;
      s      = '0;
      s.ph   = PH_MAGIC_P;
      s.maxv = 32'd255;
      return s;
   endfunction

   function automatic fx_type finish(input fx_type x, input logic [2:0] st);
      fx_type y;
      y = x;
      y.e.stat_v = 1'b1;
      y.e.stat   = st;
      y.s.done   = 1'b1;
      return y;
   endfunction

   function automatic fx_type put_channel(input fx_type x, input logic [31:0] u);
      fx_type y;
      y = x;
      y.e.chan_v   = 1'b1;
      y.e.chan_u   = u;
      y.e.chan_max = x.s.maxv;
      y.e.chan_idx = x.s.cidx;
      if (x.s.cidx == 2'd2) begin
         y.s.cidx = 2'd0;
         if (x.s.left != '0) y.s.left = x.s.left - PIX_W'(1);
         if (y.s.left == '0) y = finish(y, ST_OK);
      end else begin
         y.s.cidx = x.s.cidx + 2'd1;
      end
      return y;
   endfunction

   function automatic fx_type finish_number(input fx_type x);
      fx_type            y;
      logic [31:0]       u;
      logic [PROD_W-1:0] prod;
      y = x;
      u = x.s.acc;
      prod = PROD_W'(x.s.wid) * PROD_W'(u[DIM_W-1:0]);
      y.s.num = 1'b0;
      y.s.acc = '0;
      unique case (x.s.ph)
         PH_WIDTH: begin
            if (u == '0) y = finish(y, ST_BAD_FORMAT);
            else if (u > 32'(MAX_DIM)) y = finish(y, ST_BAD_SIZE);
            else begin
               y.s.wid = u[DIM_W-1:0];
               y.s.ph  = PH_HEIGHT;
            end
         end
         PH_HEIGHT: begin
            if (u == '0) y = finish(y, ST_BAD_FORMAT);
            else if (u > 32'(MAX_DIM)) y = finish(y, ST_BAD_SIZE);
            else if (64'(prod) > 64'(MAX_PIXELS)) y = finish(y, ST_TOO_LARGE);
            else begin
               y.s.left   = PIX_W'(prod);
               y.e.size_v = 1'b1;
               y.e.size_w = 15'(x.s.wid);
               y.e.size_h = 15'(u[DIM_W-1:0]);
               y.s.ph     = PH_MAXV;
            end
         end
         PH_MAXV: begin
            if (u == '0) y = finish(y, ST_BAD_FORMAT);
            else begin
               y.s.maxv = u;
               y.s.cidx = 2'd0;
               y.s.ph   = x.s.ascii ? PH_DATA : PH_BIN_SEP;
            end
         end
         default: y = put_channel(y, u);
      endcase
      return y;
   endfunction

   function automatic fx_type bin_sep(input fx_type x, input logic [7:0] b);
      fx_type y;
      y = x;
      if (x.s.maxv > 32'd255) y = finish(y, ST_UNEXPECTED);
      else if (b == 8'h0A) y.s.ph = PH_DATA;
      else if (b == 8'h0D) y.s.ph = PH_BIN_LF;
      else y = finish(y, ST_BAD_FORMAT);
      return y;
   endfunction

   function automatic fx_type tokenize(input fx_type x, input logic [7:0] b);
      fx_type      y;
      logic [35:0] nxt;
      y = x;
      nxt = {x.s.acc, 3'b000} + {2'b00, x.s.acc, 1'b0} + 36'(b - 8'h30);
      if (x.s.cmt) begin
         if (b == 8'h0A) y.s.cmt = 1'b0;
      end else if (x.s.num) begin
         if (is_dig(b)) begin
            y.s.acc = (nxt[35:32] != '0) ? 32'hFFFF_FFFF : nxt[31:0];
         end else if (is_ws(b)) begin
            y = finish_number(y);
            if (!y.s.done && y.s.ph == PH_BIN_SEP) y = bin_sep(y, b);
         end else begin
            y = finish(y, ST_BAD_FORMAT);
         end
      end else if (is_ws(b)) begin
         y = x;
      end else if (b == 8'h23) begin
         y.s.cmt = 1'b1;
      end else if (is_dig(b)) begin
         y.s.num = 1'b1;
         y.s.acc = 32'(b - 8'h30);
      end else begin
         y = finish(y, ST_BAD_FORMAT);
      end
      return y;
   endfunction

   // Parse one byte
   always_comb begin
      work.e = '0;
      work.s = state_ff;
      if (first_byte) begin
         work.s = idle_state();
      end
      if (!work.s.done) begin
         unique case (work.s.ph)
            PH_MAGIC_P: begin
               if (data_byte == 8'h50) work.s.ph = PH_MAGIC_NUM;
               else work = finish(work, ST_BAD_FORMAT);
            end
            PH_MAGIC_NUM: begin
               if (data_byte == 8'h33 || data_byte == 8'h36) begin
                  work.s.ascii = (data_byte == 8'h33);
                  work.s.ph    = PH_MAGIC_SP;
               end else begin
                  work = finish(work, ST_BAD_FORMAT);
               end
            end
            PH_MAGIC_SP: begin
               if (is_ws(data_byte)) work.s.ph = PH_WIDTH;
               else work = finish(work, ST_BAD_FORMAT);
            end
            PH_BIN_SEP: work = bin_sep(work, data_byte);
            PH_BIN_LF: begin
               if (data_byte == 8'h0A) work.s.ph = PH_DATA;
               else work = finish(work, ST_BAD_FORMAT);
            end
            PH_DATA: begin
               if (work.s.ascii) work = tokenize(work, data_byte);
               else work = put_channel(work, 32'(data_byte));
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXV: work = tokenize(work, data_byte);
            default: work = finish(work, ST_BAD_FORMAT);
         endcase
         // End of file: close a pending number, then report
         if (!work.s.done && final_byte) begin
            if (work.s.num) work = finish_number(work);
            if (!work.s.done) begin
               work = finish(work, (work.s.ph == PH_DATA && !work.s.ascii) ?
                                   ST_SHORT : ST_BAD_FORMAT);
            end
         end
      end
   end

   always_comb begin
      state_in = take ? work.s : state_ff;
      entry    = work.e;
      push     = take && (work.e.chan_v || work.e.size_v || work.e.stat_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idle_state();
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* design/ppd_queue.sv */
// Small FIFO of per-byte work entries between front and back.
// Depends on ppd_pkg for the entry and status types.
`default_nettype none
module ppd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  ppd_pkg::ppd_entry_type     wr_entry,
   input  wire logic                  pop,
   output ppd_pkg::ppd_entry_type     rd_entry,
   output ppd_pkg::ppd_qstat_type     qstat
);
   import ppd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ppd_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers and fill count
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      if (pop)  rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
      qstat.full  = (count_ff == CNT_W'(DEPTH));
      qstat.empty = (count_ff == '0);
      rd_entry    = slot_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!qstat.full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* design/ppd_back.sv */
// Back end: channel scaling by value*255/max, pixel assembly and result register.
// Depends on ppd_pkg; takes work entries from ppd_queue.
`default_nettype none
module ppd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  ppd_pkg::ppd_entry_type head,
   input  ppd_pkg::ppd_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [31:0]            rsp_pixel_rgba,
   output logic [14:0]            rsp_image_width,
   output logic [14:0]            rsp_image_height,
   output logic [2:0]             rsp_status,
   output logic                   rsp_last
);
   import ppd_pkg::*;

   typedef enum logic [4:0] {
      B_LOAD = 5'b00001,
      B_DIV  = 5'b00010,
      B_CHAN = 5'b00100,
      B_SIZE = 5'b01000,
      B_STAT = 5'b10000
   } bstate_type;

   bstate_type    state_ff, state_in;
   ppd_entry_type work_ff, work_in;
   logic [31:0]   rem_ff, rem_in;
   logic [7:0]    nlo_ff, nlo_in, quo_ff, quo_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [7:0]    red_ff, red_in, grn_ff, grn_in;
   logic          valid_ff, valid_in, last_ff, last_in;
   logic [1:0]    kind_ff, kind_in;
   logic [31:0]   rgba_ff, rgba_in;
   logic [14:0]   wid_ff, wid_in, hgt_ff, hgt_in;
   logic [2:0]    stat_ff, stat_in;
   logic [39:0]   numer;
   logic [32:0]   trial;
   logic          fits;
   logic          out_free;

   always_comb begin
      // Divider: numerator u*255, one quotient bit per cycle
      numer = {head.chan_u, 8'h00} - {8'h00, head.chan_u};
      trial = {rem_ff, nlo_ff[7]};
      fits  = (trial >= {1'b0, work_ff.chan_max});
      out_free = !valid_ff || !rsp_stall;

      state_in = state_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      nlo_in   = nlo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      red_in   = red_ff;
      grn_in   = grn_ff;
      valid_in = valid_ff && rsp_stall;
      last_in  = last_ff;
      kind_in  = kind_ff;
      rgba_in  = rgba_ff;
      wid_in   = wid_ff;
      hgt_in   = hgt_ff;
      stat_in  = stat_ff;
      pop      = 1'b0;

      unique case (state_ff)
         B_LOAD: begin
            // Take the next entry
            if (!qstat.empty) begin
               pop     = 1'b1;
               work_in = head;
               rem_in  = numer[39:8];
               nlo_in  = numer[7:0];
               quo_in  = '0;
               cnt_in  = '0;
               if (!head.chan_v) begin
                  state_in = B_SIZE;
               end else if (head.chan_max == '0 || head.chan_u >= head.chan_max) begin
                  quo_in   = CHAN_FULL;
                  state_in = B_CHAN;
               end else begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            rem_in = fits ? 32'(trial - {1'b0, work_ff.chan_max}) : trial[31:0];
            nlo_in = {nlo_ff[6:0], 1'b0};
            quo_in = {quo_ff[6:0], fits};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) state_in = B_CHAN;
         end
         B_CHAN: begin
            // Collect channels, emit on the third
            priority if (work_ff.chan_idx == 2'd0) begin
               red_in   = quo_ff;
               state_in = B_SIZE;
            end else if (work_ff.chan_idx == 2'd1) begin
               grn_in   = quo_ff;
               state_in = B_SIZE;
            end else if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_PIXEL;
               rgba_in  = {ALPHA_OPAQUE, quo_ff, grn_ff, red_ff};
               wid_in   = '0;
               hgt_in   = '0;
               stat_in  = ST_OK;
               last_in  = !work_ff.stat_v;
               state_in = B_SIZE;
            end
         end
         B_SIZE: begin
            if (!work_ff.size_v) begin
               state_in = B_STAT;
            end else if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_SIZE;
               rgba_in  = '0;
               wid_in   = work_ff.size_w;
               hgt_in   = work_ff.size_h;
               stat_in  = ST_OK;
               last_in  = !work_ff.stat_v;
               state_in = B_STAT;
            end
         end
         B_STAT: begin
            if (!work_ff.stat_v) begin
               state_in = B_LOAD;
            end else if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_STATUS;
               rgba_in  = '0;
               wid_in   = '0;
               hgt_in   = '0;
               stat_in  = work_ff.stat;
               last_in  = 1'b1;
               state_in = B_LOAD;
            end
         end
         default: state_in = B_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_LOAD;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      nlo_ff  <= nlo_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      red_ff  <= red_in;
      grn_ff  <= grn_in;
      last_ff <= last_in;
      kind_ff <= kind_in;
      rgba_ff <= rgba_in;
      wid_ff  <= wid_in;
      hgt_ff  <= hgt_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_pixel_rgba   = rgba_ff;
   assign rsp_image_width  = wid_ff;
   assign rsp_image_height = hgt_ff;
   assign rsp_status       = stat_ff;
   assign rsp_last         = last_ff;

`ifndef NO_ASSERTIONS
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_STATUS) |-> last_ff)
      else $error("status result not marked last");
   a_pixel_alpha: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_PIXEL) |-> (rgba_ff[31:24] == ALPHA_OPAQUE))
      else $error("pixel alpha not opaque");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < work_ff.chan_max))
      else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire

/* design/ppm_stream_decoder.sv */
// PPM (P3/P6) stream decoder top level: front parser, work queue, scaling back end.
// Depends on ppd_pkg, ppd_front, ppd_queue and ppd_back.
//
//   channel   ports                                   direction
//   request   req_valid/req_stall, data/first/final    in
//   response  rsp_valid/rsp_stall, kind..last          out
//
// The parser takes one byte per cycle while the queue has room.
// A byte with work passes the back-end load, size and status states, and with a
// channel also the channel state, after the divider state for a channel below the
// maximum (one quotient bit per cycle of the divider); a byte without work is not queued.
// Reset clears parser, queue and result valid; the parse restarts at the magic.
// A stalled result holds; the queue then fills and raises req_stall.
`default_nettype none
module ppm_stream_decoder #(
   parameter int MAX_DIM     = 16384,
   parameter int MAX_PIXELS  = 16777216,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_pixel_rgba,
   output logic [14:0]      rsp_image_width,
   output logic [14:0]      rsp_image_height,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);
   import ppd_pkg::*;

   ppd_entry_type wr_entry, rd_entry;
   ppd_qstat_type qstat;
   logic          push, pop, take;

   // Accept a byte while the queue has room
   assign req_stall = qstat.full;
   assign take      = req_valid && !req_stall;

   ppd_front #(
      .MAX_DIM   (MAX_DIM),
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .first_byte(req_first_byte),
      .final_byte(req_final_byte),
      .entry     (wr_entry),
      .push      (push)
   );

   ppd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_entry(wr_entry),
      .pop     (pop),
      .rd_entry(rd_entry),
      .qstat   (qstat)
   );

   ppd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (rd_entry),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_rgba  (rsp_pixel_rgba),
      .rsp_image_width (rsp_image_width),
      .rsp_image_height(rsp_image_height),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
